// ===== sv/cc20_pkg.sv =====
`timescale 1ns / 1ps

package cc20_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HIGH      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNTER = 3'd6;

    // "expand 32-byte k" as four little-endian words.
    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    localparam int DOUBLE_ROUNDS = 10;

    typedef logic [3:0][63:0] key_t;
    typedef logic [15:0][31:0] block_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_READ,
        ST_DATA
    } state_t;

    typedef enum logic [1:0] {
        ROT16,
        ROT12,
        ROT8,
        ROT7
    } rot_t;

    // Word idx of the initial block state.
    function automatic logic [31:0] init_word(
        input logic [3:0]  idx,
        input key_t        key,
        input logic [63:0] nonce_lo,
        input logic [31:0] nonce_hi,
        input logic [31:0] ctr
    );
        logic [31:0] w;
        case (idx)
            4'd0:    w = SIGMA0;
            4'd1:    w = SIGMA1;
            4'd2:    w = SIGMA2;
            4'd3:    w = SIGMA3;
            4'd4:    w = key[0][31:0];
            4'd5:    w = key[0][63:32];
            4'd6:    w = key[1][31:0];
            4'd7:    w = key[1][63:32];
            4'd8:    w = key[2][31:0];
            4'd9:    w = key[2][63:32];
            4'd10:   w = key[3][31:0];
            4'd11:   w = key[3][63:32];
            4'd12:   w = ctr;
            4'd13:   w = nonce_lo[31:0];
            4'd14:   w = nonce_lo[63:32];
            4'd15:   w = nonce_hi;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// ===== sv/chacha20_stream_cipher_core.sv =====
// A byte from the stored keystream block goes through ST_READ and ST_DATA to the
// output register once its request is accepted; a byte that opens a new block first
// goes through ST_ROUND (ARX steps, one add-xor-rotate per cycle in the shared unit)
// and ST_FINAL (16 feed-forward adds). ST_DATA waits while an earlier result is not
// taken; requests are accepted only in ST_IDLE. Reset clears control and configuration
// asynchronously; the keystream RAM is not cleared, as position 0 always refills it.
`timescale 1ns / 1ps

module chacha20_stream_cipher_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cc20_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               data_valid,
    output logic                               data_ready,
    input  logic [7:0]                         data_in,
    input  logic                               restart,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [7:0]                         data_out
);

    import cc20_pkg::*;

    state_t      state_reg, state_next;
    block_t      w_reg, w_next, w_upd;
    logic [1:0]  step_reg, step_next;
    logic [2:0]  qr_reg, qr_next;
    logic [3:0]  dr_reg, dr_next;
    logic [3:0]  fin_reg, fin_next;
    logic [5:0]  pos_reg, pos_next;
    logic [31:0] ctr_reg, ctr_next;
    logic [7:0]  din_reg, din_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg, out_data_next;

    key_t        key_reg;
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;
    logic [31:0] init_ctr_reg;

    logic [31:0] arx_p, arx_q, arx_s, arx_sum, arx_mix;
    rot_t        arx_rot;
    logic [1:0]  rot_amt [4];

    logic        accept;
    logic [5:0]  eff_pos;
    logic [31:0] eff_ctr;
    logic [31:0] ram_rdata;
    logic [7:0]  byte_sel;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg      <= '0;
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
            init_ctr_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_WORD0:       key_reg[0]   <= cfg_data;
                CFG_KEY_WORD1:       key_reg[1]   <= cfg_data;
                CFG_KEY_WORD2:       key_reg[2]   <= cfg_data;
                CFG_KEY_WORD3:       key_reg[3]   <= cfg_data;
                CFG_NONCE_LOW:       nonce_lo_reg <= cfg_data;
                CFG_NONCE_HIGH:      nonce_hi_reg <= cfg_data[31:0];
                CFG_INITIAL_COUNTER: init_ctr_reg <= cfg_data[31:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            qr_reg        <= '0;
            dr_reg        <= '0;
            fin_reg       <= '0;
            pos_reg       <= '0;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            qr_reg        <= qr_next;
            dr_reg        <= dr_next;
            fin_reg       <= fin_next;
            pos_reg       <= pos_next;
            ctr_reg       <= ctr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        din_reg      <= din_next;
        out_data_reg <= out_data_next;
    end

    // The quarter round always works on column 0; the rows are rotated after
    // each quarter round so that the next column (or diagonal) moves into place.
    always_comb
    begin
        arx_p   = w_reg[0];
        arx_q   = w_reg[4];
        arx_s   = w_reg[12];
        arx_rot = ROT16;
        case (state_reg)
            ST_ROUND:
            begin
                case (step_reg)
                    2'd0:
                    begin
                        arx_p = w_reg[0];  arx_q = w_reg[4];  arx_s = w_reg[12];
                        arx_rot = ROT16;
                    end
                    2'd1:
                    begin
                        arx_p = w_reg[8];  arx_q = w_reg[12]; arx_s = w_reg[4];
                        arx_rot = ROT12;
                    end
                    2'd2:
                    begin
                        arx_p = w_reg[0];  arx_q = w_reg[4];  arx_s = w_reg[12];
                        arx_rot = ROT8;
                    end
                    default:
                    begin
                        arx_p = w_reg[8];  arx_q = w_reg[12]; arx_s = w_reg[4];
                        arx_rot = ROT7;
                    end
                endcase
            end
            ST_FINAL:
            begin
                arx_p = w_reg[0];
                arx_q = init_word(fin_reg, key_reg, nonce_lo_reg, nonce_hi_reg, ctr_reg);
            end
            default:
            begin
                arx_p = w_reg[0];
            end
        endcase
    end

    cc20_arx u_arx (
        .p   (arx_p),
        .q   (arx_q),
        .s   (arx_s),
        .rot (arx_rot),
        .sum (arx_sum),
        .mix (arx_mix)
    );

    // Row r turns left by one word after every quarter round. At the end of the
    // column round it turns r further to diagonalise, and at the end of the
    // diagonal round r less to restore the column order.
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            if (qr_reg[1:0] != 2'd3)
            begin
                rot_amt[2'(r)] = 2'd1;
            end
            else if (qr_reg[2])
            begin
                rot_amt[2'(r)] = 2'd1 - 2'(r);
            end
            else
            begin
                rot_amt[2'(r)] = 2'd1 + 2'(r);
            end
        end
    end

    always_comb
    begin
        w_upd = w_reg;
        if (!step_reg[0])
        begin
            w_upd[0]  = arx_sum;
            w_upd[12] = arx_mix;
        end
        else
        begin
            w_upd[8] = arx_sum;
            w_upd[4] = arx_mix;
        end
    end

    assign accept  = data_valid && data_ready;
    assign eff_pos = restart ? 6'd0 : pos_reg;
    assign eff_ctr = restart ? init_ctr_reg : ctr_reg;
    assign byte_sel = 8'(ram_rdata >> {pos_reg[1:0], 3'b000});

    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        step_next      = step_reg;
        qr_next        = qr_reg;
        dr_next        = dr_reg;
        fin_next       = fin_reg;
        pos_next       = pos_reg;
        ctr_next       = ctr_reg;
        din_next       = din_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_data_next  = out_data_reg;
        data_ready     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                data_ready = 1'b1;
                if (accept)
                begin
                    din_next = data_in;
                    pos_next = eff_pos;
                    ctr_next = eff_ctr;
                    if (eff_pos == 6'd0)
                    begin
                        for (int i = 0; i < 16; i++)
                        begin
                            w_next[4'(i)] = init_word(4'(i), key_reg, nonce_lo_reg,
                                                      nonce_hi_reg, eff_ctr);
                        end
                        step_next  = '0;
                        qr_next    = '0;
                        dr_next    = '0;
                        state_next = ST_ROUND;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_ROUND:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg != 2'd3)
                begin
                    w_next = w_upd;
                end
                else
                begin
                    for (int r = 0; r < 4; r++)
                    begin
                        for (int c = 0; c < 4; c++)
                        begin
                            w_next[4'(4 * r + c)] =
                                w_upd[{2'(r), 2'(2'(c) + rot_amt[2'(r)])}];
                        end
                    end
                    qr_next = qr_reg + 3'd1;
                    if (qr_reg == 3'd7)
                    begin
                        dr_next = dr_reg + 4'd1;
                        if (dr_reg == 4'(DOUBLE_ROUNDS - 1))
                        begin
                            dr_next    = '0;
                            fin_next   = '0;
                            state_next = ST_FINAL;
                        end
                    end
                end
            end
            ST_FINAL:
            begin
                // Word fin_reg sits at position 0; the sum goes to the RAM.
                w_next   = {w_reg[0], w_reg[15:1]};
                fin_next = fin_reg + 4'd1;
                if (fin_reg == 4'hf)
                begin
                    ctr_next   = ctr_reg + 32'd1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = din_reg ^ byte_sel;
                    pos_next       = pos_reg + 6'd1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    cc20_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_keystream (
        .clk   (clk),
        .we    (state_reg == ST_FINAL),
        .waddr (fin_reg),
        .wdata (arx_sum),
        .re    (state_reg == ST_READ),
        .raddr (pos_reg[5:2]),
        .rdata (ram_rdata)
    );

    assign result_valid = out_valid_reg;
    assign data_out     = out_data_reg;

    a_restart_reload: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && restart) |=> (pos_reg == 6'd0 && ctr_reg == $past(init_ctr_reg))
    ) else $error("restart did not reload counter and position");

    a_mid_block_no_rounds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && !restart && pos_reg != 6'd0) |=> (state_reg == ST_READ)
    ) else $error("new block started away from position zero");

    a_counter_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINAL && fin_reg == 4'hf) |=> (ctr_reg == $past(ctr_reg) + 32'd1)
    ) else $error("block counter not advanced after a block");

endmodule

// ===== sv/cc20_ram.sv =====
`timescale 1ns / 1ps

module cc20_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/cc20_arx.sv =====
`timescale 1ns / 1ps

module cc20_arx (
    input  logic               [31:0] p,
    input  logic               [31:0] q,
    input  logic               [31:0] s,
    input  cc20_pkg::rot_t            rot,
    output logic               [31:0] sum,
    output logic               [31:0] mix
);

    import cc20_pkg::*;

    logic [31:0] x;

    assign sum = p + q;
    assign x   = s ^ sum;

    always_comb
    begin
        case (rot)
            ROT16:   mix = {x[15:0], x[31:16]};
            ROT12:   mix = {x[19:0], x[31:20]};
            ROT8:    mix = {x[23:0], x[31:24]};
            ROT7:    mix = {x[24:0], x[31:25]};
            default: mix = x;
        endcase
    end

endmodule
